// ----- rtl/tile_average_hash_compare_defines.svh -----
// assertion macros for the tile average hash block
`ifndef TILE_AVERAGE_HASH_COMPARE_DEFINES_SVH
`define TILE_AVERAGE_HASH_COMPARE_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define TAH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define TAH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tah_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_pkg
// Shared constants for the tile average hash compare block: grid size,
// field widths, divide-by-three reciprocal and controller state codes.
// ----------------------------------------------------------------------------
package tah_pkg;

  localparam int GRID_SIDE = 8;
  localparam int SAMPLES   = GRID_SIDE * GRID_SIDE;

  localparam int CHAN_W    = 8;
  localparam int GRAY_W    = 8;
  localparam int HASH_W    = 64;
  localparam int IDX_W     = 6;
  localparam int STORE_D   = 64;
  localparam int SUM_W     = 14;
  localparam int DIST_W    = 7;
  localparam int THR_W     = 7;
  localparam int SAMPLE_W  = 7;
  localparam int PROD_W    = GRAY_W + SAMPLE_W;

  // floor(s / 3) == (s * 683) >> 11 for every s up to 765
  localparam int RGB_SUM_W  = 10;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_W     = 20;

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_TAIL   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

endpackage

// ----- rtl/tah_gray.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_gray
// Gray level of one pixel: (red + green + blue) / 3, truncated, done as a
// multiply by a fixed reciprocal and a shift.
// ----------------------------------------------------------------------------
module tah_gray (
  input  logic [tah_pkg::CHAN_W-1:0] red,
  input  logic [tah_pkg::CHAN_W-1:0] green,
  input  logic [tah_pkg::CHAN_W-1:0] blue,
  output logic [tah_pkg::GRAY_W-1:0] gray
);

  logic [tah_pkg::RGB_SUM_W-1:0] rgb_sum;
  logic [tah_pkg::DIV3_W-1:0]    scaled;

  assign rgb_sum = tah_pkg::RGB_SUM_W'(red) + tah_pkg::RGB_SUM_W'(green)
                 + tah_pkg::RGB_SUM_W'(blue);
  assign scaled  = tah_pkg::DIV3_W'(rgb_sum) * tah_pkg::DIV3_W'(tah_pkg::DIV3_MUL);
  assign gray    = scaled[tah_pkg::DIV3_SHIFT +: tah_pkg::GRAY_W];

endmodule

// ----- rtl/tah_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tah_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/tile_average_hash_compare.sv -----
`timescale 1ns / 1ps
// The result is registered in the finish state, after the walk and tail states.
// Throughput: one sample per cycle while loading, then a walk of all 64 entries of the
// gray memory (one read port) and the tail and finish states for each tile.
// Samples of the next tile are refused from the walk until the result is shown.
// Reset: synchronous, clears counters, sum, state and output valid; threshold 3.
// ----------------------------------------------------------------------------
// tile_average_hash_compare
// Collects the gray samples of a tile in memory, builds the average hash by
// walking the memory once and compares it with the reference hash.
// ----------------------------------------------------------------------------
`include "tile_average_hash_compare_defines.svh"

module tile_average_hash_compare (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tah_pkg::THR_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tah_pkg::CHAN_W-1:0]    red,
  input  logic [tah_pkg::CHAN_W-1:0]    green,
  input  logic [tah_pkg::CHAN_W-1:0]    blue,
  input  logic [tah_pkg::HASH_W-1:0]    ref_hash,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tah_pkg::HASH_W-1:0]    tile_hash,
  output logic [tah_pkg::DIST_W-1:0]    bit_distance,
  output logic                          changed
);

  logic [1:0]                     state;
  logic [tah_pkg::IDX_W-1:0]      sample_count;
  logic [tah_pkg::SUM_W-1:0]      gray_sum;
  logic [tah_pkg::THR_W-1:0]      bit_threshold;
  logic [tah_pkg::IDX_W-1:0]      walk_addr;
  logic                           rd_pend;
  logic [tah_pkg::IDX_W-1:0]      rd_idx;
  logic [tah_pkg::HASH_W-1:0]     hash_acc;
  logic [tah_pkg::HASH_W-1:0]     ref_sh;
  logic [tah_pkg::DIST_W-1:0]     diff_count;

  logic [tah_pkg::GRAY_W-1:0]     gray;
  logic [tah_pkg::GRAY_W-1:0]     rd_data;
  logic                           in_take;
  logic                           last_sample;
  logic                           walk_rd;
  logic [tah_pkg::PROD_W-1:0]     scaled;
  logic                           in_grid;
  logic                           hash_bit;
  logic                           out_free;

  assign in_stall    = (state != tah_pkg::ST_LOAD);
  assign in_take     = in_valid && !in_stall;
  assign last_sample = (sample_count == tah_pkg::IDX_W'(tah_pkg::SAMPLES - 1));
  assign walk_rd     = (state == tah_pkg::ST_WALK);
  assign out_free    = !out_valid || !out_stall;

  tah_gray u_gray (
    .red   (red),
    .green (green),
    .blue  (blue),
    .gray  (gray)
  );

  tah_ram #(
    .DEPTH (tah_pkg::STORE_D),
    .WIDTH (tah_pkg::GRAY_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_take),
    .wr_addr (sample_count),
    .wr_data (gray),
    .rd_en   (walk_rd),
    .rd_addr (walk_addr),
    .rd_data (rd_data)
  );

  // sample * count >= sum stands for sample >= average
  assign scaled   = tah_pkg::PROD_W'(rd_data) * tah_pkg::PROD_W'(tah_pkg::SAMPLES);
  assign in_grid  = (tah_pkg::SAMPLE_W'(rd_idx) < tah_pkg::SAMPLE_W'(tah_pkg::SAMPLES));
  assign hash_bit = in_grid && (scaled >= tah_pkg::PROD_W'(gray_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold <= tah_pkg::THR_W'(3);
    end else if (cfg_write) begin
      bit_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tah_pkg::ST_LOAD;
      sample_count <= '0;
      gray_sum     <= '0;
      walk_addr    <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rd_pend <= walk_rd;
      if (out_valid && !out_stall && state != tah_pkg::ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        tah_pkg::ST_LOAD: begin
          if (in_take) begin
            gray_sum <= gray_sum + tah_pkg::SUM_W'(gray);
            if (last_sample) begin
              sample_count <= '0;
              walk_addr    <= '0;
              state        <= tah_pkg::ST_WALK;
            end else begin
              sample_count <= sample_count + 1'b1;
            end
          end
        end
        tah_pkg::ST_WALK: begin
          walk_addr <= walk_addr + 1'b1;
          if (walk_addr == tah_pkg::IDX_W'(tah_pkg::STORE_D - 1)) begin
            state <= tah_pkg::ST_TAIL;
          end
        end
        tah_pkg::ST_TAIL: begin
          state <= tah_pkg::ST_FINISH;
        end
        tah_pkg::ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            gray_sum  <= '0;
            state     <= tah_pkg::ST_LOAD;
          end
        end
        default: begin
          state <= tah_pkg::ST_LOAD;
        end
      endcase
    end
  end

  // walk datapath: hash shifts in from the top, reference shifts out the bottom
  always_ff @(posedge clk) begin
    if (in_take && last_sample) begin
      ref_sh     <= ref_hash;
      hash_acc   <= '0;
      diff_count <= '0;
    end else if (rd_pend) begin
      hash_acc   <= {hash_bit, hash_acc[tah_pkg::HASH_W-1:1]};
      ref_sh     <= {1'b0, ref_sh[tah_pkg::HASH_W-1:1]};
      diff_count <= diff_count + tah_pkg::DIST_W'(hash_bit ^ ref_sh[0]);
    end
    if (walk_rd) begin
      rd_idx <= walk_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tah_pkg::ST_FINISH && out_free) begin
      tile_hash    <= hash_acc;
      bit_distance <= diff_count;
      changed      <= (tah_pkg::THR_W'(diff_count) > bit_threshold);
    end
  end

  `TAH_ASSERT_NEXT(a_last_starts_walk, in_take && last_sample,
    state == tah_pkg::ST_WALK && walk_addr == '0, "last sample did not start the walk")
  `TAH_ASSERT_NOW(a_pend_in_walk, rd_pend,
    state == tah_pkg::ST_WALK || state == tah_pkg::ST_TAIL, "memory read pending outside the walk")
  `TAH_ASSERT_NOW(a_dist_range, state == tah_pkg::ST_FINISH,
    diff_count <= tah_pkg::DIST_W'(tah_pkg::HASH_W), "distance above hash width")
  `TAH_ASSERT_NOW(a_out_from_finish, $rose(out_valid),
    $past(state) == tah_pkg::ST_FINISH, "result shown without a finished walk")

endmodule
